@@ src/xph_pkg.sv @@
// Shared types, constants and helpers for the XOR phase-detector PLL.
package xph_pkg;

  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int OSC_FRAC_BITS_DEF = 30;

  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN      = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP      = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEFF     = 4'd3;

  localparam logic [11:0] THRESHOLD_RST = 12'd2047;
  localparam logic [11:0] GAIN_RST      = 12'd250;
  localparam logic [31:0] STEP_RST      = 32'd1717987;
  localparam logic [15:0] COEFF_RST     = 16'd66;

  // Divider operand width: numerators and denominators stay below 2^62
  localparam int DIV_BITS = 62;

  typedef struct packed {
    logic [11:0] threshold;
    logic [11:0] gain;
    logic [31:0] step;
    logic [15:0] coeff;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] num;
    logic [DIV_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] quot;
  } div_rsp_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

@@ src/xph_div.sv @@
// Bit-serial Q.30 divider, rounded to nearest, one quotient bit per cycle.
module xph_div (
  input  logic              clk,
  input  logic              rst,
  input  xph_pkg::div_req_t req,
  output xph_pkg::div_rsp_t rsp
);
  import xph_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_PRE, D_ITER} dstate_t;

  localparam logic [30:0] ONE_Q30 = 31'h40000000;

  dstate_t             state;
  logic [DIV_BITS:0]   r;
  logic [DIV_BITS-1:0] d;
  logic [31:0]         q;
  logic [4:0]          cnt;
  logic                done;
  logic [30:0]         quot;

  logic [DIV_BITS:0]   r_sub;
  logic [DIV_BITS:0]   r_sh;
  logic                sh_ge;
  logic [31:0]         q_next;
  logic [32:0]         q_rnd;

  // One restoring step
  always_comb begin
    r_sub  = r - {1'b0, d};
    r_sh   = {r[DIV_BITS-1:0], 1'b0};
    sh_ge  = (r_sh >= {1'b0, d});
    q_next = {q[30:0], sh_ge};
    q_rnd  = {1'b0, q_next} + 33'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        D_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            r     <= {1'b0, req.num};
            d     <= req.den;
            state <= D_PRE;
          end
        end
        D_PRE: begin
          cnt <= '0;
          if (d == '0) begin
            quot  <= ONE_Q30;
            done  <= 1'b1;
            state <= D_IDLE;
          end else if (r >= {1'b0, d}) begin
            if (r_sub >= {1'b0, d}) begin
              quot  <= ONE_Q30;
              done  <= 1'b1;
              state <= D_IDLE;
            end else begin
              r     <= r_sub;
              q     <= 32'd1;
              done  <= 1'b0;
              state <= D_ITER;
            end
          end else begin
            q     <= 32'd0;
            done  <= 1'b0;
            state <= D_ITER;
          end
        end
        D_ITER: begin
          q    <= q_next;
          r    <= sh_ge ? (r_sh - {1'b0, d}) : r_sh;
          cnt  <= cnt + 5'd1;
          done <= (cnt == 5'd30);
          if (cnt == 5'd30) begin
            quot  <= q_rnd[31:1];
            state <= D_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

@@ src/xph_core.sv @@
// Sequencer and datapath around one shared multiplier and the divider.
module xph_core #(
  parameter int SAMPLE_BITS   = xph_pkg::SAMPLE_BITS_DEF,
  parameter int OSC_FRAC_BITS = xph_pkg::OSC_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  xph_pkg::cfg_t           cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_BITS-1:0]  sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [31:0]      sine_out,
  output logic signed [31:0]      cosine_out,
  output logic                    phase_error,
  output logic [15:0]             filtered_error
);
  import xph_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_FILT, S_FILT2, S_GAIN, S_WPROD, S_H, S_HH, S_DEN,
    S_D1, S_D2, S_C1, S_C2, S_C3, S_C4, S_S1, S_S2, S_S3, S_S4
  } state_t;

  localparam logic [DIV_BITS-1:0] FOUR_Q36 = DIV_BITS'(64'd1 << 38);
  localparam logic signed [31:0]  SINE_RST = 32'sd1 <<< OSC_FRAC_BITS;

  state_t               state;
  logic signed [31:0]   pc, ps;
  logic [15:0]          pf;
  logic                 ppb;
  logic                 perr;
  logic signed [17:0]   fdiff;
  logic [15:0]          filt;
  logic [30:0]          h;
  logic signed [63:0]   prod;
  logic signed [63:0]   acc;
  logic signed [31:0]   a1, a2;
  logic                 a1_neg;
  logic signed [31:0]   nc;
  div_req_t             dreq;
  div_rsp_t             drsp;

  logic signed [32:0]   mul_a, mul_b;
  logic signed [65:0]   mul_p;
  logic [15:0]          samp_x, thr_x;
  logic signed [63:0]   f_sum;
  logic [63:0]          h_sum;
  logic signed [63:0]   c_rnd, t_rnd, s_diff;
  logic [DIV_BITS-1:0]  h2;
  logic signed [31:0]   quot_s;

  xph_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_FILT: begin
        mul_a = {17'd0, cfg.coeff};
        mul_b = 33'(fdiff);
      end
      S_GAIN: begin
        mul_a = {21'd0, cfg.gain};
        mul_b = {17'd0, filt};
      end
      S_WPROD: begin
        mul_a = {5'd0, prod[27:0]};
        mul_b = {1'b0, cfg.step};
      end
      S_HH: begin
        mul_a = {2'd0, h};
        mul_b = {2'd0, h};
      end
      S_C1: begin
        mul_a = 33'(a1);
        mul_b = 33'(pc);
      end
      S_C2: begin
        mul_a = 33'(a2);
        mul_b = 33'(ps);
      end
      S_S1: begin
        mul_a = {2'd0, h};
        mul_b = 33'(pc);
      end
      S_S2: begin
        mul_a = {2'd0, h};
        mul_b = 33'(nc);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Rounding and helpers
  always_comb begin
    samp_x = 16'(sample);
    thr_x  = 16'(cfg.threshold);
    f_sum  = 64'(signed'({1'b0, pf})) + ((prod + 64'sd32768) >>> 16);
    h_sum  = prod + 64'd536870912;
    h2     = prod[DIV_BITS-1:0];
    c_rnd  = (acc + 64'sd536870912) >>> 30;
    t_rnd  = (acc + 64'sd262144) >>> 19;
    s_diff = 64'(ps) - t_rnd;
    quot_s = {1'b0, drsp.quot};
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      dreq.start <= 1'b0;
      pc         <= '0;
      ps         <= SINE_RST;
      pf         <= '0;
      ppb        <= 1'b0;
    end else begin
      prod       <= mul_p[63:0];
      // divider start: once for a1, once for a2
      dreq.start <= (state == S_DEN) || ((state == S_D1) && drsp.done);
      if (out_valid && out_ready && (state != S_S4)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            perr  <= (samp_x >= thr_x) ^ ~pc[31];
            fdiff <= (ppb ? 18'sd65536 : 18'sd0) - 18'(signed'({1'b0, pf}));
            state <= S_FILT;
          end
        end
        S_FILT:  state <= S_FILT2;
        S_FILT2: begin
          // saturate filter output to 0..65535
          if (f_sum < 0) begin
            filt <= 16'd0;
          end else if (f_sum > 64'sd65535) begin
            filt <= 16'hFFFF;
          end else begin
            filt <= f_sum[15:0];
          end
          state <= S_GAIN;
        end
        S_GAIN:  state <= S_WPROD;
        S_WPROD: state <= S_H;
        S_H: begin
          h     <= h_sum[60:30];
          state <= S_HH;
        end
        S_HH:    state <= S_DEN;
        S_DEN: begin
          dreq.den   <= FOUR_Q36 + h2;
          a1_neg     <= (h2 > FOUR_Q36);
          dreq.num   <= (h2 > FOUR_Q36) ? (h2 - FOUR_Q36) : (FOUR_Q36 - h2);
          state      <= S_D1;
        end
        S_D1: begin
          if (drsp.done) begin
            a1         <= a1_neg ? -quot_s : quot_s;
            dreq.num   <= DIV_BITS'({h, 20'd0});
            state      <= S_D2;
          end
        end
        S_D2: begin
          if (drsp.done) begin
            a2    <= quot_s;
            state <= S_C1;
          end
        end
        S_C1: state <= S_C2;
        S_C2: begin
          acc   <= prod;
          state <= S_C3;
        end
        S_C3: begin
          acc   <= acc + prod;
          state <= S_C4;
        end
        S_C4: begin
          nc    <= sat32(c_rnd);
          state <= S_S1;
        end
        S_S1: state <= S_S2;
        S_S2: begin
          acc   <= prod;
          state <= S_S3;
        end
        S_S3: begin
          acc   <= acc + prod;
          state <= S_S4;
        end
        S_S4: begin
          // hold here until the output register is free
          if (!out_valid || out_ready) begin
            sine_out       <= sat32(s_diff);
            cosine_out     <= nc;
            phase_error    <= perr;
            filtered_error <= filt;
            out_valid      <= 1'b1;
            ps             <= sat32(s_diff);
            pc             <= nc;
            pf             <= filt;
            ppb            <= perr;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/xor_pll_harmonic_oscillator.sv @@
// Top level: configuration registers and the PLL core.
//
// XOR phase-detector PLL with a second-order harmonic oscillator.
// Input channel in_valid/in_ready carries one grid sample per request;
// output channel out_valid/out_ready carries sine_out, cosine_out,
// phase_error and filtered_error, one result per sample.
// Each sample passes from acceptance to result through the
// shared-multiplier sequencing and two passes of the bit-serial
// divider. in_ready is high only while the sequencer is idle, so one
// sample is in work at a time and a new one is taken only after the
// previous one has left the sequencer.
// A finished result sits in the output register; the next sample may be
// accepted meanwhile, and its result waits in the core until the
// receiver takes the earlier one, so a stalled receiver stalls the input.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and should only be made while idle; an index above three is ignored.
// Synchronous reset loads the register defaults, cosine zero, sine one,
// filter zero and clears both channels.
module xor_pll_harmonic_oscillator #(
  parameter int SAMPLE_BITS   = xph_pkg::SAMPLE_BITS_DEF,
  parameter int OSC_FRAC_BITS = xph_pkg::OSC_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [xph_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [xph_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 sine_out,
  output logic signed [31:0]                 cosine_out,
  output logic                               phase_error,
  output logic [15:0]                        filtered_error
);
  import xph_pkg::*;

  cfg_t cfg;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RST;
      cfg.gain      <= GAIN_RST;
      cfg.step      <= STEP_RST;
      cfg.coeff     <= COEFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: cfg.threshold <= cfg_data[11:0];
        REG_GAIN:      cfg.gain      <= cfg_data[11:0];
        REG_STEP:      cfg.step      <= cfg_data[31:0];
        REG_COEFF:     cfg.coeff     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  xph_core #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .OSC_FRAC_BITS(OSC_FRAC_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sine_out      (sine_out),
    .cosine_out    (cosine_out),
    .phase_error   (phase_error),
    .filtered_error(filtered_error)
  );

endmodule
